### rtl/core/assert_macros.svh
// Assertion macros shared by the line field tagger RTL.
// Every macro samples on clk_i; the first also ignores cycles in reset (rst_ni low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define IRCLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("irclt assertion failed");

// Checked on every edge, reset included.
`define IRCLT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("irclt assertion failed");

`endif

### rtl/core/irclt_pkg.sv
// Package for the line field tagger: field kinds, character codes, queue record.
// No dependencies.
package irclt_pkg;

  localparam int MAX_ARGS    = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int TDATA_W = 24;
  localparam int TUSER_W = 5;

  typedef enum logic [3:0] {
    KIND_DISCARD = 4'd0,
    KIND_NICK    = 4'd1,
    KIND_USER    = 4'd2,
    KIND_HOST    = 4'd3,
    KIND_CMD     = 4'd4,
    KIND_MIDDLE  = 4'd5,
    KIND_OPENER  = 4'd6,
    KIND_TRAIL   = 4'd7,
    KIND_SUMMARY = 4'd8
  } kind_e;

  // One classified byte, plus the message summary when eom is set.
  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic [3:0] arg_idx;
    logic       tok_start;
    logic       ovf;
    logic       eom;
    logic [4:0] arg_cnt;
    logic       prefix;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic logic is_space(logic [7:0] b);
    return ((b >= CH_TAB) && (b <= CH_CR)) || (b == CH_SPACE);
  endfunction

endpackage

### rtl/core/irclt_front.sv
// Front end: accepts message bytes and runs the field phase machine.
// Depends on irclt_pkg and assert_macros.svh; pushes records into irclt_queue.
`include "assert_macros.svh"

module irclt_front #(
  parameter int MaxArgs = irclt_pkg::MAX_ARGS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,  // [7:0] byte_in
  input  logic              s_axis_tlast_i,  // end_of_msg
  input  logic              full_i,
  output logic              push_o,
  output irclt_pkg::rec_t   rec_o
);
  import irclt_pkg::*;

  localparam int CW = $clog2(MaxArgs + 1);
  localparam int IW = (MaxArgs > 1) ? $clog2(MaxArgs) : 1;

  typedef enum logic [3:0] {
    PH_LEAD, PH_NICK, PH_USER, PH_HOST, PH_GAPC,
    PH_CMD, PH_GAPA, PH_ARG, PH_TRAIL, PH_DONE
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] cur_q, cur_d;
  logic          prefix_q, prefix_d;
  logic          ovf_q, ovf_d;
  logic          fresh_q, fresh_d;

  logic          accept;
  logic          ws;
  logic [7:0]    b;
  kind_e         kind;
  logic          ts;
  logic          argk;
  logic [IW+3:0] idx_ext;
  logic [CW+4:0] cnt_ext;

  assign s_axis_tready_o = ~full_i;
  assign accept          = s_axis_tvalid_i & ~full_i;
  assign push_o          = accept;
  assign b               = s_axis_tdata_i;
  assign ws              = is_space(b);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    prefix_d = prefix_q;
    ovf_d    = ovf_q;
    fresh_d  = fresh_q;
    kind     = KIND_DISCARD;
    ts       = 1'b0;
    argk     = 1'b0;
    case (phase_q)
      PH_LEAD: begin
        if (!ws) begin
          if (b == CH_COLON) begin
            prefix_d = 1'b1;
            fresh_d  = 1'b1;
            phase_d  = PH_NICK;
          end else begin
            kind    = KIND_CMD;
            ts      = 1'b1;
            phase_d = PH_CMD;
          end
        end
      end
      PH_NICK, PH_USER, PH_HOST: begin
        if (ws) begin
          phase_d = PH_GAPC;
        end else if (phase_q == PH_NICK && b == CH_BANG) begin
          fresh_d = 1'b1;
          phase_d = PH_USER;
        end else if (phase_q == PH_USER && b == CH_AT) begin
          fresh_d = 1'b1;
          phase_d = PH_HOST;
        end else begin
          kind    = (phase_q == PH_NICK) ? KIND_NICK :
                    (phase_q == PH_USER) ? KIND_USER : KIND_HOST;
          ts      = fresh_q;
          fresh_d = 1'b0;
        end
      end
      PH_GAPC: begin
        if (!ws) begin
          kind    = KIND_CMD;
          ts      = 1'b1;
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        if (ws) begin
          phase_d = PH_GAPA;
        end else begin
          kind = KIND_CMD;
        end
      end
      PH_GAPA: begin
        if (!ws) begin
          if (cnt_q < CW'(MaxArgs)) begin
            cur_d = cnt_q[IW-1:0];
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
            cur_d = IW'(MaxArgs - 1);
          end
          ts   = 1'b1;
          argk = 1'b1;
          if (b == CH_COLON) begin
            kind    = KIND_OPENER;
            phase_d = PH_TRAIL;
          end else begin
            kind    = KIND_MIDDLE;
            phase_d = PH_ARG;
          end
        end
      end
      PH_ARG: begin
        if (ws) begin
          phase_d = PH_GAPA;
        end else begin
          kind = KIND_MIDDLE;
          argk = 1'b1;
        end
      end
      PH_TRAIL: begin
        if (b == CH_LF) begin
          phase_d = PH_DONE;
        end else begin
          kind = KIND_TRAIL;
          argk = 1'b1;
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
  end

  // Narrow output fields wrap when MaxArgs outgrows them.
  assign idx_ext = {4'b0, (argk ? cur_d : {IW{1'b0}})};
  assign cnt_ext = {5'b0, cnt_d};

  always_comb begin
    rec_o.data      = b;
    rec_o.kind      = kind;
    rec_o.arg_idx   = idx_ext[3:0];
    rec_o.tok_start = ts;
    rec_o.ovf       = ovf_d;
    rec_o.eom       = s_axis_tlast_i;
    rec_o.arg_cnt   = cnt_ext[4:0];
    rec_o.prefix    = prefix_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      cnt_q    <= '0;
      cur_q    <= '0;
      prefix_q <= 1'b0;
      ovf_q    <= 1'b0;
      fresh_q  <= 1'b0;
    end else if (accept) begin
      if (s_axis_tlast_i) begin
        phase_q  <= PH_LEAD;
        cnt_q    <= '0;
        cur_q    <= '0;
        prefix_q <= 1'b0;
        ovf_q    <= 1'b0;
        fresh_q  <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        cur_q    <= cur_d;
        prefix_q <= prefix_d;
        ovf_q    <= ovf_d;
        fresh_q  <= fresh_d;
      end
    end
  end

  // Start of message carries no leftovers from the previous one.
  `IRCLT_ASSERT(a_lead_clean, (phase_q == PH_LEAD) |-> (cnt_q == '0 && !prefix_q && !ovf_q && !fresh_q))

endmodule

### rtl/core/irclt_queue.sv
// Short record queue between front and back end.
// Depends on irclt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module irclt_queue #(
  parameter int Depth = irclt_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  irclt_pkg::rec_t rec_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output irclt_pkg::rec_t rec_o
);
  import irclt_pkg::*;

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  rec_t          mem_q [Depth];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `IRCLT_ASSERT(a_cnt_bound, cnt_q <= CW'(Depth))

endmodule

### rtl/core/irclt_back.sv
// Back end: turns queued records into output transfers, adding the summary.
// Depends on irclt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module irclt_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  irclt_pkg::rec_t                 rec_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] byte_out, [11:8] arg_index, [16:12] arg_count, [17] has_prefix,
  // [18] arg_overflow, [23:19] zero
  output logic [irclt_pkg::TDATA_W-1:0]   m_axis_tdata_o,
  // [3:0] field_kind, [4] token_start
  output logic [irclt_pkg::TUSER_W-1:0]   m_axis_tuser_o,
  output logic                            m_axis_tlast_o  // last
);
  import irclt_pkg::*;

  logic               out_valid_q, out_valid_d;
  logic [TDATA_W-1:0] data_q, data_d;
  logic [TUSER_W-1:0] user_q, user_d;
  logic               last_q, last_d;
  logic               pend_q, pend_d;
  logic [4:0]         sum_cnt_q, sum_cnt_d;
  logic               sum_prefix_q, sum_prefix_d;
  logic               sum_ovf_q, sum_ovf_d;
  logic               can_load;

  assign can_load = ~out_valid_q | m_axis_tready_i;
  assign pop_o    = can_load & ~pend_q & valid_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    data_d       = data_q;
    user_d       = user_q;
    last_d       = last_q;
    pend_d       = pend_q;
    sum_cnt_d    = sum_cnt_q;
    sum_prefix_d = sum_prefix_q;
    sum_ovf_d    = sum_ovf_q;
    if (can_load) begin
      if (pend_q) begin
        out_valid_d = 1'b1;
        data_d      = {5'b0, sum_ovf_q, sum_prefix_q, sum_cnt_q, 4'b0, 8'h00};
        user_d      = {1'b0, KIND_SUMMARY};
        last_d      = 1'b1;
        pend_d      = 1'b0;
      end else if (valid_i) begin
        out_valid_d  = 1'b1;
        data_d       = {5'b0, rec_i.ovf, 1'b0, 5'b0, rec_i.arg_idx, rec_i.data};
        user_d       = {rec_i.tok_start, rec_i.kind};
        last_d       = 1'b0;
        pend_d       = rec_i.eom;
        sum_cnt_d    = rec_i.arg_cnt;
        sum_prefix_d = rec_i.prefix;
        sum_ovf_d    = rec_i.ovf;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q       <= data_d;
    user_q       <= user_d;
    last_q       <= last_d;
    sum_cnt_q    <= sum_cnt_d;
    sum_prefix_q <= sum_prefix_d;
    sum_ovf_q    <= sum_ovf_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = user_q;
  assign m_axis_tlast_o  = last_q;

  // A pending summary always sits behind the final byte's transfer.
  `IRCLT_ASSERT(a_pend_behind_byte, pend_q |-> out_valid_q)
  `IRCLT_ASSERT(a_last_is_summary, (out_valid_q && last_q) |-> (user_q[3:0] == KIND_SUMMARY))

endmodule

### rtl/core/irc_line_field_tagger.sv
// IRC line field tagger, top level: front end, record queue, back end.
// Depends on irclt_pkg, irclt_front, irclt_queue, irclt_back.
//
// Usage: bytes of one IRC message arrive on the s_axis channel, tdata the
// byte and tlast on the final byte. For every byte one transfer leaves on
// m_axis with the byte, its field kind and token start in tuser, and the
// argument index in tdata. The final byte is followed by a summary transfer
// (kind summary, tlast high) carrying argument count, prefix and overflow.
// A byte accepted on s_axis is written into the queue, then loaded into the
// output register and offered on m_axis. Throughput: one byte per cycle
// while the receiver keeps m_axis_tready high; after the final byte of a
// message the summary takes its own output transfer, and the next record waits.
// The phase machine in the front end classifies each byte as it is accepted.
// A stalled receiver holds the output register; the queue then fills and
// s_axis_tready falls once it holds QueueDepth records.
// Reset empties the queue and output register and returns the phase machine
// to the start of a message.
module irc_line_field_tagger #(
  parameter int MaxArgs    = irclt_pkg::MAX_ARGS,
  parameter int QueueDepth = irclt_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] byte_in
  input  logic                          s_axis_tlast_i,  // end_of_msg
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] byte_out, [11:8] arg_index, [16:12] arg_count, [17] has_prefix,
  // [18] arg_overflow, [23:19] zero
  output logic [irclt_pkg::TDATA_W-1:0] m_axis_tdata_o,
  // [3:0] field_kind, [4] token_start
  output logic [irclt_pkg::TUSER_W-1:0] m_axis_tuser_o,
  output logic                          m_axis_tlast_o   // last
);
  import irclt_pkg::*;

  rec_t front_rec;
  rec_t queue_rec;
  logic push;
  logic full;
  logic pop;
  logic queue_valid;

  irclt_front #(
    .MaxArgs(MaxArgs)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .full_i         (full),
    .push_o         (push),
    .rec_o          (front_rec)
  );

  irclt_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (front_rec),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(queue_valid),
    .rec_o  (queue_rec)
  );

  irclt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (queue_valid),
    .rec_i          (queue_rec),
    .pop_o          (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule
